### src/integer_to_ascii_radix_unit_defines.svh
// Assertion macros for the integer to ASCII radix unit.
// Used by the top level only; define NO_ASSERTIONS to compile them away.
`ifndef INTEGER_TO_ASCII_RADIX_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check that cond implies expr in the same cycle
`define ITOA_ASSERT_IMPL(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error(msg);
// Check that cond implies expr in the next cycle
`define ITOA_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error(msg);
`else
`define ITOA_ASSERT_IMPL(label, cond, expr, msg)
`define ITOA_ASSERT_NEXT(label, cond, expr, msg)
`endif
`endif

### src/itoa_pkg.sv
// Shared constants and helpers for the integer to ASCII radix unit.
// No dependencies.
`timescale 1ns / 1ps

package itoa_pkg;

    // Value width default and field widths
    localparam int VALUE_BITS_DEF = 32;
    localparam int RADIX_W        = 6;
    localparam int CHAR_W         = 8;

    // Radix register
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5A;

    // Quotient bits resolved per divider cycle
    localparam int STEP_BITS = 8;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_RADIX = 1'b0;

    // Map a digit value to its ASCII character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [RADIX_W-1:0] off;
        off = d - DIGIT_TEN;
        if (d < DIGIT_TEN) begin
            digit_char = CHAR_ZERO + {2'b00, d};
        end else begin
            digit_char = CHAR_A + {2'b00, off};
        end
    endfunction

endpackage

### src/integer_to_ascii_radix_unit.sv
// Integer to ASCII text in radix 2..36, most significant character first.
// Latency: each digit costs one pass through the shared divider, then each
// character goes out through the registered digit stack read.
// Throughput: one word at a time; the divider loop sets the pace.
// Reset: aresetn synchronous active low; radix returns to 10, queue empties.
`timescale 1ns / 1ps
`include "integer_to_ascii_radix_unit_defines.svh"

module integer_to_ascii_radix_unit #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input words
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0] s_tdata,  // [VALUE_BITS-1:0] value
    // Output characters
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [itoa_pkg::CHAR_W-1:0]  m_tdata,   // [7:0] char_code
    output logic                         m_tlast,   // last
    // Configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [itoa_pkg::PADDR_W-1:0] paddr,
    input  logic [itoa_pkg::PDATA_W-1:0] pwdata,
    output logic [itoa_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import itoa_pkg::*;

    localparam int DATA_W = ((VALUE_BITS + 7) / 8) * 8;
    localparam int ITEM_W = 1 + VALUE_BITS + RADIX_W;

    logic [RADIX_W-1:0]   radix_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    logic              q_push;
    logic [ITEM_W-1:0] q_item;
    logic              q_full;
    logic              q_pop;
    logic [ITEM_W-1:0] q_head;
    logic              q_not_empty;

    // Register access
    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (reg_idx == REG_RADIX) ? PDATA_W'(radix_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_write && (reg_idx == REG_RADIX)) begin
            radix_reg <= pwdata[RADIX_W-1:0];
        end
    end

    itoa_front #(
        .VALUE_BITS (VALUE_BITS),
        .DATA_W     (DATA_W),
        .ITEM_W     (ITEM_W)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .radix_i  (radix_reg),
        .q_full_i (q_full),
        .q_push_o (q_push),
        .q_item_o (q_item)
    );

    itoa_fifo #(
        .WIDTH (ITEM_W)
    ) u_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_i      (q_push),
        .din_i       (q_item),
        .full_o      (q_full),
        .pop_i       (q_pop),
        .dout_o      (q_head),
        .not_empty_o (q_not_empty)
    );

    itoa_back #(
        .VALUE_BITS (VALUE_BITS),
        .ITEM_W     (ITEM_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid_i (q_not_empty),
        .q_item_i  (q_head),
        .q_pop_o   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // A minus sign always has digits after it
    `ITOA_ASSERT_IMPL(a_minus_not_last, m_tvalid && (m_tdata == CHAR_MINUS), !m_tlast, "minus sign flagged last")
    // Only sign, decimal digits and capitals leave the block
    `ITOA_ASSERT_IMPL(a_char_set, m_tvalid, (m_tdata == CHAR_MINUS) || ((m_tdata >= CHAR_ZERO) && (m_tdata <= CHAR_NINE)) || ((m_tdata >= CHAR_A) && (m_tdata <= CHAR_Z)), "character outside the digit set")
    // Queued radix is always clamped
    `ITOA_ASSERT_IMPL(a_base_clamped, q_push, (q_item[RADIX_W-1:0] >= RADIX_MIN) && (q_item[RADIX_W-1:0] <= RADIX_MAX), "radix not clamped")
    // A pushed word is held in the queue
    `ITOA_ASSERT_NEXT(a_push_held, q_push, q_not_empty, "queue empty after a push")

endmodule

### src/itoa_front.sv
// Front end: accepts a value word, splits off the sign, forms the unsigned
// magnitude and clamps the radix. Depends on itoa_pkg.
`timescale 1ns / 1ps

module itoa_front #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF,
    parameter int DATA_W     = ((VALUE_BITS + 7) / 8) * 8,
    parameter int ITEM_W     = 1 + VALUE_BITS + itoa_pkg::RADIX_W
) (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [DATA_W-1:0]            s_tdata,   // [VALUE_BITS-1:0] value
    input  logic [itoa_pkg::RADIX_W-1:0] radix_i,
    input  logic                         q_full_i,
    output logic                         q_push_o,
    output logic [ITEM_W-1:0]            q_item_o
);
    import itoa_pkg::*;

    logic [VALUE_BITS-1:0] raw;
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
    logic [RADIX_W-1:0]    base;

    // Split sign and take the magnitude as unsigned
    assign raw = s_tdata[VALUE_BITS-1:0];
    assign neg = raw[VALUE_BITS-1];
    assign mag = neg ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;

    // Clamp the radix into its meaningful range
    always_comb begin
        if (radix_i < RADIX_MIN) begin
            base = RADIX_MIN;
        end else if (radix_i > RADIX_MAX) begin
            base = RADIX_MAX;
        end else begin
            base = radix_i;
        end
    end

    // Push into the queue while it has room
    assign s_tready = !q_full_i;
    assign q_push_o = s_tvalid && !q_full_i;
    assign q_item_o = {neg, mag, base};

endmodule

### src/itoa_fifo.sv
// Short queue of classified words between front and back end.
// Depends on itoa_pkg.
`timescale 1ns / 1ps

module itoa_fifo #(
    parameter int WIDTH = 1 + itoa_pkg::VALUE_BITS_DEF + itoa_pkg::RADIX_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_i,
    input  logic [WIDTH-1:0] din_i,
    output logic             full_o,
    input  logic             pop_i,
    output logic [WIDTH-1:0] dout_o,
    output logic             not_empty_o
);
    import itoa_pkg::*;

    logic [WIDTH-1:0]  slot_reg [QUEUE_DEPTH];
    logic [QIDX_W-1:0] wr_ptr_reg;
    logic [QIDX_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full_o      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty_o = (count_reg != '0);
    assign dout_o      = slot_reg[rd_ptr_reg];
    assign do_push     = push_i && !full_o;
    assign do_pop      = pop_i && not_empty_o;

    // Store incoming word
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= din_i;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QIDX_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QIDX_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

### src/itoa_div.sv
// Iterative divider of the magnitude by the radix, STEP_BITS quotient bits
// per cycle (restoring). Depends on itoa_pkg.
`timescale 1ns / 1ps

module itoa_div #(
    parameter int DIV_W = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start_i,
    input  logic [DIV_W-1:0]             dividend_i,
    input  logic [itoa_pkg::RADIX_W-1:0] divisor_i,
    output logic                         done_o,
    output logic [DIV_W-1:0]             quot_o,
    output logic [itoa_pkg::RADIX_W-1:0] rem_o
);
    import itoa_pkg::*;

    localparam int STEPS = DIV_W / STEP_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DIV_W-1:0]   quot_reg;
    logic [DIV_W-1:0]   quot_next;
    logic [RADIX_W-1:0] rem_reg;
    logic [RADIX_W-1:0] rem_next;
    logic [RADIX_W-1:0] div_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    // Resolve STEP_BITS quotient bits
    always_comb begin
        logic [DIV_W-1:0]   q_t;
        logic [RADIX_W:0]   r_w;
        logic [RADIX_W-1:0] r_t;
        q_t = quot_reg;
        r_t = rem_reg;
        for (int k = 0; k < STEP_BITS; k++) begin
            r_w = {r_t, q_t[DIV_W-1]};
            q_t = {q_t[DIV_W-2:0], 1'b0};
            if (r_w >= {1'b0, div_reg}) begin
                r_w    = r_w - {1'b0, div_reg};
                q_t[0] = 1'b1;
            end
            r_t = r_w[RADIX_W-1:0];
        end
        quot_next = q_t;
        rem_next  = r_t;
    end

    // Load on start, iterate, pulse done at the end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start_i) begin
            quot_reg <= dividend_i;
            rem_reg  <= '0;
            div_reg  <= divisor_i;
            cnt_reg  <= CNT_W'(STEPS);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign done_o = done_reg;
    assign quot_o = quot_reg;
    assign rem_o  = rem_reg;

endmodule

### src/itoa_back.sv
// Back end: repeated division into a digit stack, then emission of the
// sign and the digits most significant first. Depends on itoa_pkg, itoa_div.
`timescale 1ns / 1ps

module itoa_back #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF,
    parameter int ITEM_W     = 1 + VALUE_BITS + itoa_pkg::RADIX_W
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid_i,
    input  logic [ITEM_W-1:0]           q_item_i,
    output logic                        q_pop_o,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [itoa_pkg::CHAR_W-1:0] m_tdata,   // [7:0] char_code
    output logic                        m_tlast
);
    import itoa_pkg::*;

    localparam int DIV_W = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int PTR_W = $clog2(VALUE_BITS + 1);
    localparam int IDX_W = $clog2(VALUE_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_FETCH,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    logic               neg_reg;
    logic [RADIX_W-1:0] base_reg;
    logic [PTR_W-1:0]   ptr_reg;
    logic [PTR_W-1:0]   ptr_m1;
    logic               start_reg;
    logic               start_next;
    logic [DIV_W-1:0]   dividend_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_last_reg;
    logic               out_free;
    logic               out_load;

    logic [RADIX_W-1:0] digit_mem [VALUE_BITS];
    logic [RADIX_W-1:0] rd_data_reg;
    logic               wr_en;

    logic               div_done;
    logic [DIV_W-1:0]   div_quot;
    logic [RADIX_W-1:0] div_rem;

    itoa_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (start_reg),
        .dividend_i (dividend_reg),
        .divisor_i  (base_reg),
        .done_o     (div_done),
        .quot_o     (div_quot),
        .rem_o      (div_rem)
    );

    assign q_pop_o  = (state_reg == ST_IDLE) && q_valid_i;
    assign out_free = !out_valid_reg || m_tready;
    assign wr_en    = (state_reg == ST_DIV) && div_done;
    assign ptr_m1   = ptr_reg - PTR_W'(1);

    // Start a division on a new word or while the quotient is not yet zero
    assign start_next = ((state_reg == ST_IDLE) && q_valid_i) ||
                        ((state_reg == ST_DIV) && div_done && (div_quot != '0));
    // Load the output register with a sign or a digit
    assign out_load   = out_free && ((state_reg == ST_SIGN) || (state_reg == ST_EMIT));

    // Digit stack: push remainders, read top with registered data
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            digit_mem[ptr_reg[IDX_W-1:0]] <= div_rem;
        end
        rd_data_reg <= digit_mem[ptr_m1[IDX_W-1:0]];
    end

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            start_reg <= start_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid_i) begin
                        neg_reg      <= q_item_i[ITEM_W-1];
                        base_reg     <= q_item_i[RADIX_W-1:0];
                        dividend_reg <= DIV_W'(q_item_i[RADIX_W +: VALUE_BITS]);
                        ptr_reg      <= '0;
                        state_reg    <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        ptr_reg <= ptr_reg + PTR_W'(1);
                        if (div_quot == '0) begin
                            state_reg <= neg_reg ? ST_SIGN : ST_FETCH;
                        end else begin
                            dividend_reg <= div_quot;
                        end
                    end
                end
                ST_SIGN: begin
                    if (out_free) begin
                        out_char_reg  <= CHAR_MINUS;
                        out_last_reg  <= 1'b0;
                        state_reg     <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        out_char_reg  <= digit_char(rd_data_reg);
                        out_last_reg  <= (ptr_reg == PTR_W'(1));
                        ptr_reg       <= ptr_m1;
                        state_reg     <= (ptr_reg == PTR_W'(1)) ? ST_IDLE : ST_FETCH;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

endmodule
